### design/csc_pkg.sv
// Package for the climate sensor compensation block: widths, register codes,
// calibration and stage structures, and the 32-bit wrapping arithmetic helpers.
// Depends on nothing; every other design file imports it.
package csc_pkg;

    localparam int unsigned WORD_W             = 32;
    localparam int unsigned PADDR_W            = 6;
    localparam int unsigned PDATA_W            = 64;
    localparam int unsigned RAW_T_W            = 20;
    localparam int unsigned RAW_P_W            = 20;
    localparam int unsigned RAW_H_W            = 16;
    localparam int unsigned TEMP_W             = 15;
    localparam int unsigned PRES_W             = 11;
    localparam int unsigned HUM_W              = 17;
    localparam int unsigned DIV_BITS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES         = WORD_W / DIV_BITS_PER_STAGE;

    localparam logic [WORD_W-1:0] TEMP_MIN  = 32'hFFFF_F060;
    localparam logic [WORD_W-1:0] TEMP_MAX  = 32'd8500;
    localparam logic [WORD_W-1:0] PRES_LOW  = 32'd30000;
    localparam logic [WORD_W-1:0] PRES_HIGH = 32'd110000;
    localparam logic [PRES_W-1:0] HPA_MIN   = 11'd300;
    localparam logic [PRES_W-1:0] HPA_MAX   = 11'd1100;
    localparam logic [WORD_W-1:0] HUM_LIMIT = 32'd419430400;
    localparam logic [HUM_W-1:0]  HUM_MAX   = 17'd102400;
    // Reciprocal of 100 scaled by 2^24; exact for values up to 110000.
    localparam logic [17:0]       RECIP_100 = 18'd167773;

    typedef enum logic [2:0] {
        REG_CAL_TEMPERATURE   = 3'd0,
        REG_CAL_PRESSURE_LOW  = 3'd1,
        REG_CAL_PRESSURE_HIGH = 3'd2,
        REG_CAL_MIXED         = 3'd3,
        REG_CAL_HUMIDITY      = 3'd4
    } reg_idx_t;

    // Coefficients, each widened to a 32-bit pattern as the formulas use it.
    typedef struct packed {
        logic [WORD_W-1:0] t1, t2, t3;
        logic [WORD_W-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [WORD_W-1:0] h1, h2, h3, h4, h5, h6;
    } cal_t;

    typedef struct packed {
        logic [WORD_W-1:0]  fine;
        logic [WORD_W-1:0]  vh;
        logic [RAW_P_W-1:0] adc_p;
        logic [RAW_H_W-1:0] adc_h;
    } front_t;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]  hum;
        logic              zero;
        logic              hi;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } mid_t;

    typedef struct packed {
        side_t             side;
        logic [WORD_W-1:0] quot;
    } quot_t;

    function automatic logic [WORD_W-1:0] mul32(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [2*WORD_W-1:0] p;
        p = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        return p[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] asr32(input logic [WORD_W-1:0] x,
                                                 input int unsigned n);
        return WORD_W'($signed(x) >>> n);
    endfunction

    // Signed division by 2^n, truncating toward zero.
    function automatic logic [WORD_W-1:0] sdiv2n(input logic [WORD_W-1:0] x,
                                                  input int unsigned n);
        logic [WORD_W-1:0] mag;
        logic [WORD_W-1:0] q;
        mag = x[WORD_W-1] ? (~x + 1'b1) : x;
        q   = mag >> n;
        return x[WORD_W-1] ? (~q + 1'b1) : q;
    endfunction

    function automatic logic [WORD_W-1:0] sx(input logic [WORD_W-1:0] v,
                                              input int unsigned w);
        logic [WORD_W-1:0] r;
        r = v;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (i >= w)
            begin
                r[i] = v[w-1];
            end
        end
        return r;
    endfunction

endpackage

### design/csc_if.sv
// Valid/ready channel interfaces for raw samples and compensated results.
// Depends on csc_pkg for the field widths.
interface csc_sample_if;
    import csc_pkg::*;
    logic               valid;
    logic               ready;
    logic [RAW_T_W-1:0] raw_temperature;
    logic [RAW_P_W-1:0] raw_pressure;
    logic [RAW_H_W-1:0] raw_humidity;
    modport source (output valid, raw_temperature, raw_pressure, raw_humidity,
                    input ready);
    modport sink (input valid, raw_temperature, raw_pressure, raw_humidity,
                  output ready);
endinterface

interface csc_result_if;
    import csc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic [PRES_W-1:0]        pressure_hpa;
    logic [HUM_W-1:0]         humidity_q10;
    modport source (output valid, temperature_centi, pressure_hpa, humidity_q10,
                    input ready);
    modport sink (input valid, temperature_centi, pressure_hpa, humidity_q10,
                  output ready);
endinterface

### design/csc_front.sv
// Three-stage front end: forms the fine temperature from the raw reading.
// Depends on csc_pkg.
module csc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [csc_pkg::RAW_T_W-1:0]   raw_t,
    input  logic [csc_pkg::RAW_P_W-1:0]   raw_p,
    input  logic [csc_pkg::RAW_H_W-1:0]   raw_h,
    input  csc_pkg::cal_t                 cal,
    output logic                          out_valid,
    output csc_pkg::front_t               out_data
);
    import csc_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0]  ma;
        logic [WORD_W-1:0]  cc;
        logic [RAW_P_W-1:0] adc_p;
        logic [RAW_H_W-1:0] adc_h;
    } st_t;

    st_t    s1_reg, s1_next, s2_reg, s2_next;
    front_t s3_reg, s3_next;
    logic [2:0] vld_reg;

    always_comb
    begin
        logic [WORD_W-1:0] t32, x1, c;
        t32           = {{(WORD_W-RAW_T_W){1'b0}}, raw_t};
        x1            = (t32 >> 3) - (cal.t1 << 1);
        c             = (t32 >> 4) - cal.t1;
        s1_next.ma    = mul32(x1, cal.t2);
        s1_next.cc    = mul32(c, c);
        s1_next.adc_p = raw_p;
        s1_next.adc_h = raw_h;

        s2_next       = s1_reg;
        s2_next.ma    = asr32(s1_reg.ma, 11);
        s2_next.cc    = mul32(asr32(s1_reg.cc, 12), cal.t3);

        s3_next.fine  = s2_reg.ma + asr32(s2_reg.cc, 14);
        s3_next.vh    = s3_next.fine - 32'd76800;
        s3_next.adc_p = s2_reg.adc_p;
        s3_next.adc_h = s2_reg.adc_h;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = s3_reg;
endmodule

### design/csc_mid.sv
// Seven-stage middle section: temperature clamp, the pressure divisor and
// dividend, and the whole humidity formula, side by side.
// Depends on csc_pkg.
module csc_mid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  csc_pkg::front_t in_data,
    input  csc_pkg::cal_t   cal,
    output logic            out_valid,
    output csc_pkg::mid_t   out_data
);
    import csc_pkg::*;

    // Generic stage record: pressure words x/y/z, humidity words u/w.
    typedef struct packed {
        logic [TEMP_W-1:0]  temp;
        logic [RAW_P_W-1:0] adc_p;
        logic [RAW_H_W-1:0] adc_h;
        logic [WORD_W-1:0]  x, y, z, k;
        logic [WORD_W-1:0]  u, w, m;
    } st_t;

    st_t  s1_reg, s1_next, s2_reg, s2_next, s3_reg, s3_next;
    st_t  s4_reg, s4_next, s5_reg, s5_next, s6_reg, s6_next;
    mid_t s7_reg, s7_next;
    logic [6:0] vld_reg;

    always_comb
    begin
        logic [WORD_W-1:0] tf, pa, vr;
        // Stage 1: temperature clamp, pressure offsets, humidity products.
        tf = asr32((in_data.fine << 2) + in_data.fine + 32'd128, 8);
        if ($signed(tf) < $signed(TEMP_MIN))
        begin
            tf = TEMP_MIN;
        end
        if ($signed(tf) > $signed(TEMP_MAX))
        begin
            tf = TEMP_MAX;
        end
        pa            = sdiv2n(in_data.fine, 1) - 32'd64000;
        s1_next.temp  = tf[TEMP_W-1:0];
        s1_next.adc_p = in_data.adc_p;
        s1_next.adc_h = in_data.adc_h;
        s1_next.x     = pa;
        s1_next.y     = sdiv2n(pa, 2);
        s1_next.z     = '0;
        s1_next.k     = '0;
        s1_next.u     = mul32(cal.h5, in_data.vh);
        s1_next.w     = mul32(in_data.vh, cal.h6);
        s1_next.m     = mul32(in_data.vh, cal.h3);

        // Stage 2: x = a*p5, y = c*c, z = p2*a; u = humidity offset term.
        s2_next   = s1_reg;
        s2_next.x = mul32(s1_reg.x, cal.p5);
        s2_next.y = mul32(s1_reg.y, s1_reg.y);
        s2_next.z = mul32(cal.p2, s1_reg.x);
        s2_next.u = asr32(({{(WORD_W-RAW_H_W){1'b0}}, s1_reg.adc_h} << 14)
                          - (cal.h4 << 20) - s1_reg.u + 32'd16384, 15);
        s2_next.w = mul32(asr32(s1_reg.w, 10), asr32(s1_reg.m, 11) + 32'd32768);

        // Stage 3: k = p6 term, y = p3 term, z = p2 term halved.
        s3_next   = s2_reg;
        s3_next.k = mul32(sdiv2n(s2_reg.y, 11), cal.p6);
        s3_next.y = mul32(cal.p3, sdiv2n(s2_reg.y, 13));
        s3_next.z = sdiv2n(s2_reg.z, 1);
        s3_next.w = mul32(asr32(s2_reg.w, 10) + 32'd2097152, cal.h2);

        // Stage 4: k = pressure offset b, x = divisor seed; w = humidity product.
        s4_next   = s3_reg;
        s4_next.k = sdiv2n(s3_reg.k + (s3_reg.x << 1), 2) + (cal.p4 << 16);
        s4_next.x = sdiv2n(sdiv2n(s3_reg.y, 3) + s3_reg.z, 18);
        s4_next.w = mul32(s3_reg.u, asr32(s3_reg.w + 32'd8192, 14));

        // Stage 5: x = scaled divisor; m = square of the humidity estimate.
        s5_next   = s4_reg;
        s5_next.x = mul32(32'd32768 + s4_reg.x, cal.p1);
        s5_next.m = mul32(asr32(s4_reg.w, 15), asr32(s4_reg.w, 15));

        // Stage 6: x = divisor, y = dividend before doubling; m = h1 term.
        s6_next   = s5_reg;
        s6_next.x = sdiv2n(s5_reg.x, 15);
        s6_next.y = mul32((32'd1048576 - {{(WORD_W-RAW_P_W){1'b0}}, s5_reg.adc_p})
                          - sdiv2n(s5_reg.k, 12), 32'd3125);
        s6_next.m = mul32(asr32(s5_reg.m, 7), cal.h1);

        // Stage 7: dividend form, zero divisor, humidity clamp.
        s7_next.side.temp = s6_reg.temp;
        s7_next.side.hi   = s6_reg.y[WORD_W-1];
        s7_next.side.zero = (s6_reg.x == '0);
        s7_next.dividend  = s6_reg.y[WORD_W-1] ? s6_reg.y : (s6_reg.y << 1);
        s7_next.divisor   = s6_reg.x;
        vr = s6_reg.w - asr32(s6_reg.m, 4);
        if (vr[WORD_W-1])
        begin
            s7_next.side.hum = '0;
        end
        else if (vr > HUM_LIMIT)
        begin
            s7_next.side.hum = HUM_MAX;
        end
        else
        begin
            s7_next.side.hum = vr[HUM_W+11:12];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            s7_reg <= s7_next;
        end
    end

    assign out_valid = vld_reg[6];
    assign out_data  = s7_reg;
endmodule

### design/csc_div.sv
// Pipelined restoring divider for the pressure quotient, a fixed number of
// quotient bits per stage, with the other results carried alongside.
// Depends on csc_pkg.
module csc_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  csc_pkg::mid_t in_data,
    output logic          out_valid,
    output csc_pkg::quot_t out_data
);
    import csc_pkg::*;

    typedef struct packed {
        side_t             side;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quot;
        logic [WORD_W-1:0] den;
    } dst_t;

    dst_t st_reg  [DIV_STAGES];
    dst_t st_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            dst_t src;
            if (k == 0)
            begin : g_first
                always_comb
                begin
                    src.side = in_data.side;
                    src.num  = in_data.dividend;
                    src.rem  = '0;
                    src.quot = '0;
                    src.den  = in_data.divisor;
                end
            end
            else
            begin : g_rest
                assign src = st_reg[k-1];
            end

            always_comb
            begin
                logic [WORD_W:0] r;
                st_next[k] = src;
                for (int i = 0; i < DIV_BITS_PER_STAGE; i++)
                begin
                    r = {st_next[k].rem, st_next[k].num[WORD_W-1]};
                    st_next[k].num = st_next[k].num << 1;
                    if (r >= {1'b0, st_next[k].den})
                    begin
                        r = r - {1'b0, st_next[k].den};
                        st_next[k].quot = {st_next[k].quot[WORD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        st_next[k].quot = {st_next[k].quot[WORD_W-2:0], 1'b0};
                    end
                    st_next[k].rem = r[WORD_W-1:0];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    st_reg[k] <= st_next[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    assign out_valid     = vld_reg[DIV_STAGES-1];
    assign out_data.side = st_reg[DIV_STAGES-1].side;
    assign out_data.quot = st_reg[DIV_STAGES-1].quot;
endmodule

### design/csc_post.sv
// Four-stage pressure refinement after the divider, range check and
// conversion to hPa; its last stage is the block's output register.
// Depends on csc_pkg.
module csc_post (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_valid,
    input  csc_pkg::quot_t                  in_data,
    input  csc_pkg::cal_t                   cal,
    output logic                            out_valid,
    output logic signed [csc_pkg::TEMP_W-1:0] temp,
    output logic [csc_pkg::PRES_W-1:0]      pres,
    output logic [csc_pkg::HUM_W-1:0]       hum
);
    import csc_pkg::*;

    typedef struct packed {
        side_t             side;
        logic [WORD_W-1:0] pr;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
    } pst_t;

    typedef struct packed {
        side_t       side;
        logic        low;
        logic        high;
        logic [16:0] pv;
    } rng_t;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [PRES_W-1:0] pres;
        logic [HUM_W-1:0]  hum;
    } res_t;

    pst_t s1_reg, s1_next, s2_reg, s2_next;
    rng_t s3_reg, s3_next;
    res_t s4_reg, s4_next;
    logic [3:0] vld_reg;

    always_comb
    begin
        logic [WORD_W-1:0] pr, p2;
        logic [34:0]       prod;
        pr         = in_data.side.hi ? (in_data.quot << 1) : in_data.quot;
        s1_next.side = in_data.side;
        s1_next.pr = pr;
        s1_next.x  = mul32(pr >> 3, pr >> 3);
        s1_next.y  = mul32(pr >> 2, cal.p8);

        s2_next    = s1_reg;
        s2_next.x  = mul32(cal.p9, s1_reg.x >> 13);
        s2_next.y  = sdiv2n(s1_reg.y, 13);

        p2 = s2_reg.pr + sdiv2n(sdiv2n(s2_reg.x, 12) + s2_reg.y + cal.p7, 4);
        s3_next.side = s2_reg.side;
        s3_next.low  = p2 < PRES_LOW;
        s3_next.high = p2 > PRES_HIGH;
        s3_next.pv   = p2[16:0];

        prod          = 35'(s3_reg.pv) * 35'(RECIP_100);
        s4_next.temp  = s3_reg.side.temp;
        s4_next.hum   = s3_reg.side.hum;
        if (s3_reg.side.zero || s3_reg.low)
        begin
            s4_next.pres = HPA_MIN;
        end
        else if (s3_reg.high)
        begin
            s4_next.pres = HPA_MAX;
        end
        else
        begin
            s4_next.pres = prod[24+PRES_W-1:24];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign temp      = s4_reg.temp;
    assign pres      = s4_reg.pres;
    assign hum       = s4_reg.hum;
endmodule

### design/climate_sensor_compensation_top.sv
// Top level of the climate sensor compensation block: calibration registers,
// APB-style port and the pipeline chain. Depends on csc_pkg, csc_if and the
// csc_front, csc_mid, csc_div and csc_post modules.
//
// Usage:
//   Raw readings arrive on the sample channel, one transfer per reading set;
//   each gives exactly one transfer on the result channel, in order.
//   From acceptance to a valid result a reading set passes 3 front stages
//   (fine temperature), 7 middle stages, 16 divider stages (two quotient
//   bits each) and 4 output stages. Throughput is one reading set per cycle
//   unless stalled. The whole pipeline advances together whenever the output
//   register is empty or being taken; a stalled receiver freezes every stage,
//   so the sample channel's ready falls only while a result waits at the output.
//   Calibration is written through the APB-style port, register i at byte
//   address 8*i, only while the pipeline is empty (a rule for the user, not
//   enforced). Reset clears all valid bits and the calibration registers to zero.
module climate_sensor_compensation_top (
    input  logic                            clk,
    input  logic                            rst_n,
    csc_sample_if.sink                      sample_ch,
    csc_result_if.source                    result_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csc_pkg::PADDR_W-1:0]     paddr,
    input  logic [csc_pkg::PDATA_W-1:0]     pwdata,
    output logic [csc_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import csc_pkg::*;

    logic [47:0] cal_t_reg;
    logic [63:0] cal_pl_reg;
    logic [63:0] cal_ph_reg;
    logic [47:0] cal_mx_reg;
    logic [31:0] cal_h_reg;
    reg_idx_t    idx;
    logic        wr_en;
    cal_t        cal;

    logic   adv;
    logic   f_valid, m_valid, d_valid;
    front_t f_data;
    mid_t   m_data;
    quot_t  d_data;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_t_reg  <= '0;
            cal_pl_reg <= '0;
            cal_ph_reg <= '0;
            cal_mx_reg <= '0;
            cal_h_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CAL_TEMPERATURE:   cal_t_reg  <= pwdata[47:0];
                REG_CAL_PRESSURE_LOW:  cal_pl_reg <= pwdata;
                REG_CAL_PRESSURE_HIGH: cal_ph_reg <= pwdata;
                REG_CAL_MIXED:         cal_mx_reg <= pwdata[47:0];
                REG_CAL_HUMIDITY:      cal_h_reg  <= pwdata[31:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CAL_TEMPERATURE:   prdata = {16'd0, cal_t_reg};
            REG_CAL_PRESSURE_LOW:  prdata = cal_pl_reg;
            REG_CAL_PRESSURE_HIGH: prdata = cal_ph_reg;
            REG_CAL_MIXED:         prdata = {16'd0, cal_mx_reg};
            REG_CAL_HUMIDITY:      prdata = {32'd0, cal_h_reg};
            default:               prdata = '0;
        endcase
    end

    always_comb
    begin
        cal.t1 = {16'd0, cal_t_reg[15:0]};
        cal.t2 = sx({16'd0, cal_t_reg[31:16]}, 16);
        cal.t3 = sx({16'd0, cal_t_reg[47:32]}, 16);
        cal.p1 = {16'd0, cal_pl_reg[15:0]};
        cal.p2 = sx({16'd0, cal_pl_reg[31:16]}, 16);
        cal.p3 = sx({16'd0, cal_pl_reg[47:32]}, 16);
        cal.p4 = sx({16'd0, cal_pl_reg[63:48]}, 16);
        cal.p5 = sx({16'd0, cal_ph_reg[15:0]}, 16);
        cal.p6 = sx({16'd0, cal_ph_reg[31:16]}, 16);
        cal.p7 = sx({16'd0, cal_ph_reg[47:32]}, 16);
        cal.p8 = sx({16'd0, cal_ph_reg[63:48]}, 16);
        cal.p9 = sx({16'd0, cal_mx_reg[15:0]}, 16);
        cal.h1 = {24'd0, cal_mx_reg[23:16]};
        cal.h2 = sx({16'd0, cal_mx_reg[39:24]}, 16);
        cal.h3 = {24'd0, cal_mx_reg[47:40]};
        cal.h4 = sx({20'd0, cal_h_reg[11:0]}, 12);
        cal.h5 = sx({20'd0, cal_h_reg[23:12]}, 12);
        cal.h6 = sx({24'd0, cal_h_reg[31:24]}, 8);
    end

    // The pipeline moves as one whenever the output register can be refilled.
    assign adv             = !result_ch.valid || result_ch.ready;
    assign sample_ch.ready = adv;

    csc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (sample_ch.valid),
        .raw_t    (sample_ch.raw_temperature),
        .raw_p    (sample_ch.raw_pressure),
        .raw_h    (sample_ch.raw_humidity),
        .cal      (cal),
        .out_valid(f_valid),
        .out_data (f_data)
    );

    csc_mid u_mid (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (f_valid),
        .in_data  (f_data),
        .cal      (cal),
        .out_valid(m_valid),
        .out_data (m_data)
    );

    csc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (m_valid),
        .in_data  (m_data),
        .out_valid(d_valid),
        .out_data (d_data)
    );

    csc_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (d_valid),
        .in_data  (d_data),
        .cal      (cal),
        .out_valid(result_ch.valid),
        .temp     (result_ch.temperature_centi),
        .pres     (result_ch.pressure_hpa),
        .hum      (result_ch.humidity_q10)
    );

`ifndef SYNTHESIS
    a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (result_ch.pressure_hpa >= HPA_MIN)
                            && (result_ch.pressure_hpa <= HPA_MAX))
        else $error("pressure result outside 300..1100");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (result_ch.humidity_q10 <= HUM_MAX))
        else $error("humidity result above 102400");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> ($signed(result_ch.temperature_centi) >= -15'sd4000)
                            && ($signed(result_ch.temperature_centi) <= 15'sd8500))
        else $error("temperature result outside -4000..8500");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && !result_ch.ready) |=> result_ch.valid
            && $stable(result_ch.temperature_centi)
            && $stable(result_ch.pressure_hpa)
            && $stable(result_ch.humidity_q10))
        else $error("stalled result changed before its transfer");
`endif
endmodule
